[src/pff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types, sizes and codes of the peer freshness filter.
// ----------------------------------------------------------------------------
package pff_pkg;

   // sizing
   localparam int MAX_SENDERS = 8;
   localparam int SEQ_BITS    = 32;
   localparam int AGE_BITS    = 16;
   localparam int IDX_W       = $clog2(MAX_SENDERS);
   localparam int TIMEOUT_W   = 16;
   localparam int COUNT_W     = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 2;

   // shared adder width covers sequence, age and timeout operands
   localparam int ALU_W_A = (SEQ_BITS > AGE_BITS) ? SEQ_BITS : AGE_BITS;
   localparam int ALU_W   = (ALU_W_A > TIMEOUT_W) ? ALU_W_A : TIMEOUT_W;

   // operation codes
   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_VERSION = 3'd1;
   localparam logic [2:0] ST_BAD_ID      = 3'd2;
   localparam logic [2:0] ST_ECHO        = 3'd3;
   localparam logic [2:0] ST_STALE       = 3'd4;
   localparam logic [2:0] ST_DONE        = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  version;
      logic [7:0]  sender_id;
      logic [31:0] sequence_req;
   } pff_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] live_senders;
   } pff_rsp_type;

   // slot store write controls
   typedef struct packed {
      logic                active_en;
      logic                active;
      logic                seq_en;
      logic [SEQ_BITS-1:0] seq;
      logic                age_en;
      logic [AGE_BITS-1:0] age;
   } pff_slot_wr_type;

   // slot store read data
   typedef struct packed {
      logic                active;
      logic [SEQ_BITS-1:0] seq;
      logic [AGE_BITS-1:0] age;
   } pff_slot_rd_type;

   // shared adder operands
   typedef struct packed {
      logic [ALU_W-1:0] x;
      logic [ALU_W-1:0] y;
      logic             cin;
   } pff_alu_op_type;

endpackage

[src/pff_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_alu
// Shared adder: sequence compare, age increment and age/timeout compare.
// ----------------------------------------------------------------------------
module pff_alu (
   input  pff_pkg::pff_alu_op_type   alu_op,
   output logic [pff_pkg::ALU_W:0]   alu_sum
);

   // x + y + cin with carry out on the top bit
   assign alu_sum = {1'b0, alu_op.x} + {1'b0, alu_op.y}
                    + {{pff_pkg::ALU_W{1'b0}}, alu_op.cin};

endmodule

[src/pff_slot_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_slot_store
// Per-sender active flag, last sequence and age, one slot per access.
// ----------------------------------------------------------------------------
module pff_slot_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pff_pkg::IDX_W-1:0]     slot_idx,
   input  pff_pkg::pff_slot_wr_type      slot_wr,
   output pff_pkg::pff_slot_rd_type      slot_rd
);

   logic                         active_ff [pff_pkg::MAX_SENDERS];
   logic [pff_pkg::SEQ_BITS-1:0] seq_ff    [pff_pkg::MAX_SENDERS];
   logic [pff_pkg::AGE_BITS-1:0] age_ff    [pff_pkg::MAX_SENDERS];

   // active flags clear at reset; sequence and age are rewritten on activation
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pff_pkg::MAX_SENDERS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else if (slot_wr.active_en) begin
         active_ff[slot_idx] <= slot_wr.active;
      end
   end

   // sequence and age storage
   always_ff @(posedge clock) begin
      if (slot_wr.seq_en) begin
         seq_ff[slot_idx] <= slot_wr.seq;
      end
      if (slot_wr.age_en) begin
         age_ff[slot_idx] <= slot_wr.age;
      end
   end

   // read of the selected slot
   assign slot_rd.active = active_ff[slot_idx];
   assign slot_rd.seq    = seq_ff[slot_idx];
   assign slot_rd.age    = age_ff[slot_idx];

endmodule

[src/peer_freshness_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_freshness_filter_unit
// Per-sender sequence filter with liveness timeout, one slot per cycle.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A packet header is
// accepted and then checked and updated on the addressed sender slot in
// S_PKT. A tick or a poll walks all MAX_SENDERS slots, one per cycle
// through the single shared adder. An unused op code is answered from idle
// with ST_DONE. Each result appears on rsp_word for exactly one cycle with
// rsp_valid high, the cycle after the last work cycle; the receiver cannot
// stall it, so it must capture it then.
// Configuration writes on csr_we take effect at once and are meant for idle.
// ----------------------------------------------------------------------------
module peer_freshness_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pff_pkg::pff_req_type                req_word,
   output logic                                rsp_valid,
   output pff_pkg::pff_rsp_type                rsp_word,
   input  logic                                csr_we,
   input  logic [pff_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pff_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PKT  = 4'b0010,
      S_TICK = 4'b0100,
      S_POLL = 4'b1000
   } pff_state_type;

   localparam logic [pff_pkg::IDX_W-1:0] LAST_IDX =
      pff_pkg::IDX_W'(pff_pkg::MAX_SENDERS - 1);
   localparam logic [pff_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   pff_state_type                   state_ff, state_in;
   logic [pff_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [pff_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   pff_pkg::pff_req_type            word_ff, word_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pff_pkg::pff_rsp_type            rsp_ff, rsp_in;
   logic [2:0]                      local_id_ff;
   logic [7:0]                      version_ff;
   logic [pff_pkg::TIMEOUT_W-1:0]   timeout_ff;

   pff_pkg::pff_slot_wr_type        slot_wr;
   pff_pkg::pff_slot_rd_type        slot_rd;
   pff_pkg::pff_alu_op_type         alu_op;
   logic [pff_pkg::ALU_W:0]         alu_sum;

   logic                            carry;
   logic [pff_pkg::SEQ_BITS-1:0]    seq_lat;
   logic                            age_gt;
   logic                            keep;
   logic [pff_pkg::COUNT_W-1:0]     cnt_next;
   logic [2:0]                      pkt_status;

   pff_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .slot_idx (idx_ff),
      .slot_wr  (slot_wr),
      .slot_rd  (slot_rd)
   );

   pff_alu u_alu (
      .alu_op  (alu_op),
      .alu_sum (alu_sum)
   );

   assign carry   = alu_sum[pff_pkg::ALU_W];
   assign seq_lat = word_ff.sequence_req[pff_pkg::SEQ_BITS-1:0];
   assign age_gt  = ~carry;
   assign keep    = slot_rd.active & ~age_gt;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff <= 3'd0;
         version_ff  <= 8'd1;
         timeout_ff  <= pff_pkg::TIMEOUT_W'(1000);
      end else if (csr_we) begin
         case (csr_index)
            pff_pkg::CSR_LOCAL_ID: local_id_ff <= csr_wdata[2:0];
            pff_pkg::CSR_VERSION:  version_ff  <= csr_wdata[7:0];
            pff_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_wdata[pff_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // shared adder operand select
   always_comb begin
      alu_op.x   = '0;
      alu_op.y   = '0;
      alu_op.cin = 1'b1;
      case (state_ff)
         S_PKT: begin
            // carry set when sequence <= stored sequence
            alu_op.x = pff_pkg::ALU_W'(slot_rd.seq);
            alu_op.y = ~pff_pkg::ALU_W'(seq_lat);
         end
         S_TICK: begin
            alu_op.x = pff_pkg::ALU_W'(slot_rd.age);
         end
         S_POLL: begin
            // carry clear when age exceeds timeout
            alu_op.x = pff_pkg::ALU_W'(timeout_ff);
            alu_op.y = ~pff_pkg::ALU_W'(slot_rd.age);
         end
         default: ;
      endcase
   end

   // packet checks in priority order
   always_comb begin
      if (word_ff.version != version_ff) begin
         pkt_status = pff_pkg::ST_BAD_VERSION;
      end else if (word_ff.sender_id >= 8'(pff_pkg::MAX_SENDERS)) begin
         pkt_status = pff_pkg::ST_BAD_ID;
      end else if (word_ff.sender_id == {5'd0, local_id_ff}) begin
         pkt_status = pff_pkg::ST_ECHO;
      end else if (slot_rd.active && carry) begin
         pkt_status = pff_pkg::ST_STALE;
      end else begin
         pkt_status = pff_pkg::ST_OK;
      end
   end

   // saturating live count
   assign cnt_next = (keep && cnt_ff != COUNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      slot_wr      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               word_in = req_word;
               case (req_word.op)
                  pff_pkg::OP_PACKET: begin
                     state_in = S_PKT;
                     idx_in   = req_word.sender_id[pff_pkg::IDX_W-1:0];
                  end
                  pff_pkg::OP_TICK: begin
                     state_in = S_TICK;
                     idx_in   = '0;
                  end
                  pff_pkg::OP_POLL: begin
                     state_in = S_POLL;
                     idx_in   = '0;
                     cnt_in   = '0;
                  end
                  default: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.status       = pff_pkg::ST_DONE;
                     rsp_in.live_senders = '0;
                  end
               endcase
            end
         end
         S_PKT: begin
            if (pkt_status == pff_pkg::ST_OK) begin
               slot_wr.active_en = 1'b1;
               slot_wr.active    = 1'b1;
               slot_wr.seq_en    = 1'b1;
               slot_wr.seq       = seq_lat;
               slot_wr.age_en    = 1'b1;
               slot_wr.age       = '0;
            end
            rsp_valid_in        = 1'b1;
            rsp_in.status       = pkt_status;
            rsp_in.live_senders = '0;
            state_in            = S_IDLE;
         end
         S_TICK: begin
            // overflow out of the age width means the age is saturated
            slot_wr.age_en = ~alu_sum[pff_pkg::AGE_BITS];
            slot_wr.age    = alu_sum[pff_pkg::AGE_BITS-1:0];
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = pff_pkg::ST_DONE;
               rsp_in.live_senders = '0;
               state_in            = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_POLL: begin
            slot_wr.active_en = slot_rd.active & age_gt;
            slot_wr.active    = 1'b0;
            cnt_in            = cnt_next;
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = pff_pkg::ST_DONE;
               rsp_in.live_senders = cnt_next;
               state_in            = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
